[rtl/bsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg
// shared constants, widths and the cordic angle table for the bearing check
// ----------------------------------------------------------------------------
package bsc_pkg;

	// parameter defaults
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int POS_WIDTH_DEF    = 24;

	// fixed field widths
	localparam int HEAD_W = 16;
	localparam int CFG_W  = 16;
	localparam int BEAR_W = 16;
	localparam int IDX_W  = 1;

	// register indexes
	localparam logic [IDX_W-1:0] REG_SECTOR_MIN = 1'b0;
	localparam logic [IDX_W-1:0] REG_SECTOR_MAX = 1'b1;

	// register reset values
	localparam logic [CFG_W-1:0] SECTOR_MIN_RST = 16'd0;
	localparam logic [CFG_W-1:0] SECTOR_MAX_RST = 16'd36000;

	// dot product grows by the heading width plus two bits over the position
	localparam int DOT_EXTRA = 18;
	// normalization target: larger magnitude lands in [2^47, 2^48)
	localparam int NORM_TOP    = 48;
	localparam int NORM_STAGES = 6;

	// derived default datapath widths
	localparam int DW_DEF = POS_WIDTH_DEF + DOT_EXTRA;
	localparam int MW_DEF = (DW_DEF > NORM_TOP) ? DW_DEF : NORM_TOP;
	localparam int CW_DEF = MW_DEF + 3;

	// angle accumulator, 1/1024 of a hundredth of a degree
	localparam int ZW        = 27;
	localparam int FRAC_BITS = 10;
	localparam logic signed [ZW-1:0] ANG_90      = 27'sd9216000;
	localparam logic signed [ZW-1:0] ANG_HALF    = 27'sd512;
	localparam logic signed [ZW-1:0] ANG_FULL    = 27'sd36000;
	localparam logic [BEAR_W-1:0]    BEARING_FULL = 16'd36000;

	localparam int ATAN_N = 24;
	localparam logic [23:0] ATAN_TAB [ATAN_N] = '{
		24'd4608000, 24'd2720261, 24'd1437311, 24'd729602,
		24'd366217,  24'd183287,  24'd91666,   24'd45836,
		24'd22918,   24'd11459,   24'd5730,    24'd2865,
		24'd1432,    24'd716,     24'd358,     24'd179,
		24'd90,      24'd45,      24'd22,      24'd11,
		24'd6,       24'd3,       24'd1,       24'd1
	};

endpackage

[rtl/bsc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_front
// offset, heading products and dot products, then magnitudes for normalizing
// ----------------------------------------------------------------------------
module bsc_front #(
	parameter int POS_WIDTH = bsc_pkg::POS_WIDTH_DEF,
	parameter int DW        = bsc_pkg::DW_DEF,
	parameter int MW        = bsc_pkg::MW_DEF,
	parameter int CW        = bsc_pkg::CW_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [POS_WIDTH-1:0]      target_x,
	input  logic signed [POS_WIDTH-1:0]      target_y,
	input  logic signed [POS_WIDTH-1:0]      self_x,
	input  logic signed [POS_WIDTH-1:0]      self_y,
	input  logic signed [bsc_pkg::HEAD_W-1:0] fwd_x,
	input  logic signed [bsc_pkg::HEAD_W-1:0] fwd_y,
	input  logic signed [bsc_pkg::HEAD_W-1:0] right_x,
	input  logic signed [bsc_pkg::HEAD_W-1:0] right_y,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [CW-1:0]             x,
	output logic signed [CW-1:0]             y,
	output logic        [MW-1:0]             m,
	output logic                             zero
);

	localparam int OW = POS_WIDTH + 1;
	localparam int PW = POS_WIDTH + bsc_pkg::HEAD_W + 1;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	logic signed [OW-1:0] dx_s1, dy_s1;
	logic signed [bsc_pkg::HEAD_W-1:0] fx_s1, fy_s1, rx_s1, ry_s1;
	logic signed [PW-1:0] pfx_s2, pfy_s2, prx_s2, pry_s2;
	logic signed [DW-1:0] fd_s3, rd_s3;
	logic signed [DW-1:0] fa, ra;
	logic signed [CW-1:0] x_s4, y_s4;
	logic [MW-1:0] m_s4;
	logic zero_s4;

	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	assign fa = fd_s3[DW-1] ? -fd_s3 : fd_s3;
	assign ra = rd_s3[DW-1] ? -rd_s3 : rd_s3;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			dx_s1 <= $signed({target_x[POS_WIDTH-1], target_x})
				- $signed({self_x[POS_WIDTH-1], self_x});
			dy_s1 <= $signed({target_y[POS_WIDTH-1], target_y})
				- $signed({self_y[POS_WIDTH-1], self_y});
			fx_s1 <= fwd_x;
			fy_s1 <= fwd_y;
			rx_s1 <= right_x;
			ry_s1 <= right_y;
		end
		if (rdy2) begin
			pfx_s2 <= fx_s1 * dx_s1;
			pfy_s2 <= fy_s1 * dy_s1;
			prx_s2 <= rx_s1 * dx_s1;
			pry_s2 <= ry_s1 * dy_s1;
		end
		if (rdy3) begin
			fd_s3 <= DW'(pfx_s2) + DW'(pfy_s2);
			rd_s3 <= DW'(prx_s2) + DW'(pry_s2);
		end
		if (rdy4) begin
			x_s4    <= CW'(fd_s3);
			y_s4    <= CW'(rd_s3);
			// or of the magnitudes keeps the top bit of the larger one
			m_s4    <= MW'(fa | ra);
			zero_s4 <= (fd_s3 == '0) && (rd_s3 == '0);
		end
	end

	assign out_valid = v_s4;
	assign x         = x_s4;
	assign y         = y_s4;
	assign m         = m_s4;
	assign zero      = zero_s4;

endmodule

[rtl/bsc_norm_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_norm_cell
// one normalize step: shift left by SHIFT when the result stays below 2^48
// ----------------------------------------------------------------------------
module bsc_norm_cell #(
	parameter int SHIFT = 1,
	parameter int MW    = bsc_pkg::MW_DEF,
	parameter int CW    = bsc_pkg::CW_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [CW-1:0] x_in,
	input  logic signed [CW-1:0] y_in,
	input  logic        [MW-1:0] m_in,
	input  logic                 zero_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [CW-1:0] x_out,
	output logic signed [CW-1:0] y_out,
	output logic        [MW-1:0] m_out,
	output logic                 zero_out
);

	logic v_s1;
	logic fits;
	logic signed [CW-1:0] x_s1, y_s1;
	logic [MW-1:0] m_s1;
	logic zero_s1;

	assign in_ready = !v_s1 || out_ready;
	assign fits     = (m_in >> (bsc_pkg::NORM_TOP - SHIFT)) == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			x_s1    <= fits ? (x_in <<< SHIFT) : x_in;
			y_s1    <= fits ? (y_in <<< SHIFT) : y_in;
			m_s1    <= fits ? (m_in << SHIFT) : m_in;
			zero_s1 <= zero_in;
		end
	end

	assign out_valid = v_s1;
	assign x_out     = x_s1;
	assign y_out     = y_s1;
	assign m_out     = m_s1;
	assign zero_out  = zero_s1;

endmodule

[rtl/bsc_cordic_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_cordic_cell
// one vectoring cordic micro-rotation, driving y toward zero
// ----------------------------------------------------------------------------
module bsc_cordic_cell #(
	parameter int STEP = 0,
	parameter int CW   = bsc_pkg::CW_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [CW-1:0]              x_in,
	input  logic signed [CW-1:0]              y_in,
	input  logic signed [bsc_pkg::ZW-1:0]     z_in,
	input  logic                              zero_in,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [CW-1:0]              x_out,
	output logic signed [CW-1:0]              y_out,
	output logic signed [bsc_pkg::ZW-1:0]     z_out,
	output logic                              zero_out
);

	localparam logic signed [bsc_pkg::ZW-1:0] ANG = bsc_pkg::ZW'(bsc_pkg::ATAN_TAB[STEP]);

	logic v_s1;
	logic pos;
	logic signed [CW-1:0] xs, ys;
	logic signed [CW-1:0] x_s1, y_s1;
	logic signed [bsc_pkg::ZW-1:0] z_s1;
	logic zero_s1;

	assign in_ready = !v_s1 || out_ready;
	// arithmetic shift rounds toward minus infinity
	assign xs  = x_in >>> STEP;
	assign ys  = y_in >>> STEP;
	assign pos = !y_in[CW-1] && (y_in != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			if (pos) begin
				x_s1 <= x_in + ys;
				y_s1 <= y_in - xs;
				z_s1 <= z_in + ANG;
			end else begin
				x_s1 <= x_in - ys;
				y_s1 <= y_in + xs;
				z_s1 <= z_in - ANG;
			end
			zero_s1 <= zero_in;
		end
	end

	assign out_valid = v_s1;
	assign x_out     = x_s1;
	assign y_out     = y_s1;
	assign z_out     = z_s1;
	assign zero_out  = zero_s1;

endmodule

[rtl/bearing_sector_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bearing_sector_check
// clockwise bearing of a target from a heading by pipelined cordic, and a
// test against a configurable, possibly wrapping, sector
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake           payload
//  s_axis    in         s_tvalid/s_tready   s_tdata: positions and headings
//  m_axis    out        m_tvalid/m_tready   m_tdata: bearing, m_tuser: in_sector
//  cfg       in         cfg_we              cfg_index, cfg_data
//
//  one transfer per cycle in and out while m_tready is high; the stages are
//  4 front stages, 6 normalize cells, a quadrant stage, one cordic cell per
//  step, a rounding stage and the output register
//  reset clears every stage valid bit and loads the sector defaults, no sweep
//  each stage holds while the one after it is full and stalled; empty stages
//  still load, so bubbles close up and s_tready only falls once the whole
//  chain is full behind a stalled m_tready
//
module bearing_sector_check #(
	parameter int CORDIC_STEPS = bsc_pkg::CORDIC_STEPS_DEF,
	parameter int POS_WIDTH    = bsc_pkg::POS_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// target_x, target_y, self_x, self_y, fwd_x, fwd_y, right_x, right_y
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [((4*POS_WIDTH + 4*bsc_pkg::HEAD_W + 7) / 8) * 8 - 1:0] s_tdata,
	// bearing
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [bsc_pkg::BEAR_W-1:0]    m_tdata,
	// in_sector
	output logic [0:0]                    m_tuser,
	input  logic                          cfg_we,
	input  logic [bsc_pkg::IDX_W-1:0]     cfg_index,
	input  logic [bsc_pkg::CFG_W-1:0]     cfg_data
);

	localparam int HW = bsc_pkg::HEAD_W;
	localparam int ZW = bsc_pkg::ZW;
	localparam int DW = POS_WIDTH + bsc_pkg::DOT_EXTRA;
	localparam int MW = (DW > bsc_pkg::NORM_TOP) ? DW : bsc_pkg::NORM_TOP;
	localparam int CW = MW + 3;
	localparam int NS = bsc_pkg::NORM_STAGES;

	// field offsets inside s_tdata
	localparam int O_TX = 0;
	localparam int O_TY = POS_WIDTH;
	localparam int O_SX = 2 * POS_WIDTH;
	localparam int O_SY = 3 * POS_WIDTH;
	localparam int O_FX = 4 * POS_WIDTH;
	localparam int O_FY = O_FX + HW;
	localparam int O_RX = O_FX + 2 * HW;
	localparam int O_RY = O_FX + 3 * HW;

	// sector registers
	logic [bsc_pkg::CFG_W-1:0] sector_min_q, sector_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sector_min_q <= bsc_pkg::SECTOR_MIN_RST;
			sector_max_q <= bsc_pkg::SECTOR_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bsc_pkg::REG_SECTOR_MIN: sector_min_q <= cfg_data;
				bsc_pkg::REG_SECTOR_MAX: sector_max_q <= cfg_data;
			endcase
		end
	end

	// normalize chain wiring, index 0 is the front output
	logic                 nv [NS+1];
	logic                 nr [NS+1];
	logic signed [CW-1:0] nx [NS+1];
	logic signed [CW-1:0] ny [NS+1];
	logic        [MW-1:0] nm [NS+1];
	logic                 nz [NS+1];

	// cordic chain wiring, index 0 is the quadrant stage output
	logic                 cv [CORDIC_STEPS+1];
	logic                 cr [CORDIC_STEPS+1];
	logic signed [CW-1:0] cx [CORDIC_STEPS+1];
	logic signed [CW-1:0] cy [CORDIC_STEPS+1];
	logic signed [ZW-1:0] cz [CORDIC_STEPS+1];
	logic                 czr [CORDIC_STEPS+1];

	bsc_front #(
		.POS_WIDTH(POS_WIDTH),
		.DW       (DW),
		.MW       (MW),
		.CW       (CW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.target_x ($signed(s_tdata[O_TX +: POS_WIDTH])),
		.target_y ($signed(s_tdata[O_TY +: POS_WIDTH])),
		.self_x   ($signed(s_tdata[O_SX +: POS_WIDTH])),
		.self_y   ($signed(s_tdata[O_SY +: POS_WIDTH])),
		.fwd_x    ($signed(s_tdata[O_FX +: HW])),
		.fwd_y    ($signed(s_tdata[O_FY +: HW])),
		.right_x  ($signed(s_tdata[O_RX +: HW])),
		.right_y  ($signed(s_tdata[O_RY +: HW])),
		.out_valid(nv[0]),
		.out_ready(nr[0]),
		.x        (nx[0]),
		.y        (ny[0]),
		.m        (nm[0]),
		.zero     (nz[0])
	);

	// binary shift search: 32, 16, 8, 4, 2, 1
	for (genvar k = 0; k < NS; k++) begin : g_norm
		bsc_norm_cell #(
			.SHIFT(1 << (NS - 1 - k)),
			.MW   (MW),
			.CW   (CW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (nv[k]),
			.in_ready (nr[k]),
			.x_in     (nx[k]),
			.y_in     (ny[k]),
			.m_in     (nm[k]),
			.zero_in  (nz[k]),
			.out_valid(nv[k+1]),
			.out_ready(nr[k+1]),
			.x_out    (nx[k+1]),
			.y_out    (ny[k+1]),
			.m_out    (nm[k+1]),
			.zero_out (nz[k+1])
		);
	end

	// quadrant stage: left half-plane turned by 90 deg toward forward
	logic                 v_s1, rdy1;
	logic signed [CW-1:0] x_s1, y_s1;
	logic signed [ZW-1:0] z_s1;
	logic                 zero_s1;
	logic signed [CW-1:0] qx, qy;

	assign qx = nx[NS];
	assign qy = ny[NS];
	assign rdy1   = !v_s1 || cr[0];
	assign nr[NS] = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= nv[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			if (qx[CW-1] && !qy[CW-1]) begin
				x_s1 <= qy;
				y_s1 <= -qx;
				z_s1 <= bsc_pkg::ANG_90;
			end else if (qx[CW-1]) begin
				x_s1 <= -qy;
				y_s1 <= qx;
				z_s1 <= -bsc_pkg::ANG_90;
			end else begin
				x_s1 <= qx;
				y_s1 <= qy;
				z_s1 <= '0;
			end
			zero_s1 <= nz[NS];
		end
	end

	assign cv[0]  = v_s1;
	assign cx[0]  = x_s1;
	assign cy[0]  = y_s1;
	assign cz[0]  = z_s1;
	assign czr[0] = zero_s1;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		bsc_cordic_cell #(
			.STEP(i),
			.CW  (CW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (cv[i]),
			.in_ready (cr[i]),
			.x_in     (cx[i]),
			.y_in     (cy[i]),
			.z_in     (cz[i]),
			.zero_in  (czr[i]),
			.out_valid(cv[i+1]),
			.out_ready(cr[i+1]),
			.x_out    (cx[i+1]),
			.y_out    (cy[i+1]),
			.z_out    (cz[i+1]),
			.zero_out (czr[i+1])
		);
	end

	// rounding stage: round to hundredths, fold negatives into 0..35999
	logic                      v_s2, rdy2, rdy3;
	logic [bsc_pkg::BEAR_W-1:0] bearing_s2;
	logic signed [ZW-1:0]      zsum, zr, zw;

	assign rdy2             = !v_s2 || rdy3;
	assign cr[CORDIC_STEPS] = rdy2;
	assign zsum = cz[CORDIC_STEPS] + bsc_pkg::ANG_HALF;
	assign zr   = zsum >>> bsc_pkg::FRAC_BITS;
	assign zw   = zr[ZW-1] ? (zr + bsc_pkg::ANG_FULL) : zr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= cv[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			// both dots zero: bearing is defined as zero
			bearing_s2 <= czr[CORDIC_STEPS] ? '0 : zw[bsc_pkg::BEAR_W-1:0];
		end
	end

	// output register with the sector test
	logic                      v_s3;
	logic [bsc_pkg::BEAR_W-1:0] bearing_s3;
	logic                      in_sector_s3;
	logic                      above_min, below_max, hit;

	assign rdy3      = !v_s3 || m_tready;
	assign above_min = bearing_s2 >= sector_min_q;
	assign below_max = bearing_s2 <= sector_max_q;
	// sector wraps past zero when min is above max
	assign hit       = (sector_min_q <= sector_max_q) ? (above_min && below_max)
		: (above_min || below_max);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			bearing_s3   <= bearing_s2;
			in_sector_s3 <= hit;
		end
	end

	assign m_tvalid   = v_s3;
	assign m_tdata    = bearing_s3;
	assign m_tuser[0] = in_sector_s3;

endmodule

[rtl/bsc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_port_checks
// port-level checks on the bearing sector check, bound to the top level
// ----------------------------------------------------------------------------
module bsc_port_checks (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [bsc_pkg::BEAR_W-1:0] m_tdata,
	input logic [0:0]                 m_tuser
);

	// a stalled result holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// bearing always lands in 0..35999
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata < bsc_pkg::BEARING_FULL))
		else $error("bearing out of range");

	// input only backs up behind a stalled output
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled while output free");

	// a full chain that stays stalled keeps the input stalled
	a_full_stays: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready && !m_tready |=> !s_tready || m_tready)
		else $error("stalled chain freed input");

endmodule

bind bearing_sector_check bsc_port_checks u_bsc_port_checks (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
